// ----- design/radix_number_to_text_core_assert.svh -----
// ----------------------------------------------------------------------------
// Radix number to text core: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RADIX_NUMBER_TO_TEXT_CORE_ASSERT_SVH
`define RADIX_NUMBER_TO_TEXT_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RNTT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rntt assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define RNTT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rntt assertion failed");

`endif

// ----- design/rntt_pkg.sv -----
// ----------------------------------------------------------------------------
// Radix number to text: shared package
// Widths, codes, controller/datapath interface types and the digit table.
// ----------------------------------------------------------------------------
package rntt_pkg;

  // Width of the converted word; the input port stays 32 bits wide.
  localparam int NumberWidth = 32;
  localparam int InWidth     = 32;

  // Long division retires this many quotient bits per cycle.
  localparam int DivSteps      = 8;
  localparam int DivW          = ((NumberWidth + DivSteps - 1) / DivSteps) * DivSteps;
  localparam int StepsPerDigit = DivW / DivSteps;
  localparam int StepCntW      = (StepsPerDigit > 1) ? $clog2(StepsPerDigit) : 1;

  // Digit store: one entry per possible digit (radix 2 is the worst case).
  localparam int DigitW   = 4;
  localparam int StoreDep = NumberWidth;
  localparam int AddrW    = $clog2(StoreDep);
  localparam int CntW     = $clog2(NumberWidth + 1);

  localparam int CharW  = 7;
  localparam int RadixW = 5;
  localparam int FlagsW = 2;
  localparam int CfgW   = 5;

  typedef enum logic {
    CfgRadix = 1'b0,
    CfgFlags = 1'b1
  } rntt_cfg_idx_e;

  localparam int FlagUnsigned = 0;
  localparam int FlagLower    = 1;

  localparam logic [RadixW-1:0] RadixMin   = 5'd2;
  localparam logic [RadixW-1:0] RadixMax   = 5'd16;
  localparam logic [RadixW-1:0] RadixReset = 5'd10;

  localparam logic [CharW-1:0] CharMinus = 7'h2D;
  localparam logic [CharW-1:0] CharZero  = 7'h30;
  localparam logic [CharW-1:0] CharUpper = 7'h41;
  localparam logic [CharW-1:0] CharLower = 7'h61;

  typedef enum logic [2:0] {
    StIdle,
    StDivide,
    StSign,
    StFetch,
    StSend
  } rntt_state_e;

  typedef struct packed {
    logic load;        // capture a new word
    logic step;        // run one division cycle
    logic fetch;       // read the next stored digit
    logic emit_minus;  // present the minus sign on the output
  } rntt_cmd_t;

  typedef struct packed {
    logic step_last;   // this division cycle finishes a digit
    logic quo_zero;    // the quotient after this cycle is zero
    logic minus;       // the text starts with a minus sign
    logic cnt_zero;    // no stored digits remain
  } rntt_status_t;

  function automatic logic [CharW-1:0] digit_char(input logic [DigitW-1:0] digit,
                                                  input logic lower);
    logic [CharW-1:0] ch;
    if (digit < 4'd10) begin
      ch = CharZero + CharW'(digit);
    end else if (lower) begin
      ch = CharLower + CharW'(digit - 4'd10);
    end else begin
      ch = CharUpper + CharW'(digit - 4'd10);
    end
    return ch;
  endfunction

endpackage

// ----- design/radix_number_to_text_core.sv -----
// Sequence: the word is taken, then the divider makes one pass per digit
// (8 quotient bits per cycle over a 32-bit word), then each output
// character is a digit store read, then a transfer; a minus sign, if any,
// goes out first. Throughput: one word at a time; a new word is taken only
// after its last character is transferred, and the output side may stall.
// Reset: asynchronous, active low; radix returns to 10, flags to signed and
// uppercase, and the controller to idle. The digit store is not cleared.
// ----------------------------------------------------------------------------
// Radix number to text core
// Converts one integer word into ASCII text in a radix from 2 to 16, one
// character per output transfer, most significant digit first.
// ----------------------------------------------------------------------------
module radix_number_to_text_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write port: index 0 is radix, index 1 is format flags.
  input  logic                         cfg_we_i,
  input  rntt_pkg::rntt_cfg_idx_e      cfg_index_i,
  input  logic [rntt_pkg::CfgW-1:0]    cfg_data_i,
  // Input word channel.
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [rntt_pkg::InWidth-1:0] number_bits_i,
  // Output character channel.
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [rntt_pkg::CharW-1:0]   char_code_o,
  output logic                         last_char_o
);

  // The controller only issues commands; all arithmetic and storage lives in
  // the datapath. Digits come out of the divider least significant first and
  // are written into the digit store, then read back in reverse order.
  rntt_pkg::rntt_cmd_t    cmd;
  rntt_pkg::rntt_status_t status;

  rntt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // A zero word still makes one pass through the divider, so it yields the
  // single digit zero. The most negative signed word negates to itself and is
  // then converted as an unsigned magnitude.
  rntt_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .number_bits_i(number_bits_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .char_code_o  (char_code_o),
    .last_char_o  (last_char_o)
  );

endmodule

// ----- design/rntt_ram.sv -----
// ----------------------------------------------------------------------------
// Radix number to text: generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rntt_ram #(
  parameter int Width = 4,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/rntt_dpath.sv -----
// ----------------------------------------------------------------------------
// Radix number to text: datapath
// Configuration registers, iterative divider, digit store and output mux.
// ----------------------------------------------------------------------------
module rntt_dpath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  rntt_pkg::rntt_cfg_idx_e              cfg_index_i,
  input  logic [rntt_pkg::CfgW-1:0]            cfg_data_i,
  input  logic [rntt_pkg::InWidth-1:0]         number_bits_i,
  input  rntt_pkg::rntt_cmd_t                  cmd_i,
  output rntt_pkg::rntt_status_t               status_o,
  output logic [rntt_pkg::CharW-1:0]           char_code_o,
  output logic                                 last_char_o
);

  logic [rntt_pkg::RadixW-1:0]        radix_q;
  logic [rntt_pkg::FlagsW-1:0]        flags_q;
  logic [rntt_pkg::DivW-1:0]          div_q, div_d;
  logic [rntt_pkg::DigitW-1:0]        rem_q, rem_d;
  logic [rntt_pkg::StepCntW-1:0]      step_q;
  logic [rntt_pkg::CntW-1:0]          cnt_q, cnt_dec;
  logic                               minus_q;
  logic [rntt_pkg::NumberWidth-1:0]   word, mag;
  logic                               neg;
  logic                               step_last;
  logic [rntt_pkg::DigitW-1:0]        rd_digit;
  logic [rntt_pkg::DivSteps-1:0]      qbits;

  // Clamp radix writes into the legal range.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= rntt_pkg::RadixReset;
      flags_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rntt_pkg::CfgRadix: begin
          if (cfg_data_i < rntt_pkg::RadixMin) begin
            radix_q <= rntt_pkg::RadixMin;
          end else if (cfg_data_i > rntt_pkg::RadixMax) begin
            radix_q <= rntt_pkg::RadixMax;
          end else begin
            radix_q <= cfg_data_i;
          end
        end
        rntt_pkg::CfgFlags: flags_q <= cfg_data_i[rntt_pkg::FlagsW-1:0];
        default: ;
      endcase
    end
  end

  assign word = rntt_pkg::NumberWidth'(number_bits_i);
  assign neg  = !flags_q[rntt_pkg::FlagUnsigned] && word[rntt_pkg::NumberWidth-1];
  assign mag  = neg ? (~word + 1'b1) : word;

  // Restoring long division by the radix, DivSteps bits per cycle. Quotient
  // bits shift in at the bottom, so after one pass div_q holds the quotient.
  always_comb begin
    logic [rntt_pkg::DivSteps-1:0] chunk;
    logic [rntt_pkg::DigitW-1:0]   r;
    logic [rntt_pkg::RadixW-1:0]   t;
    chunk = div_q[rntt_pkg::DivW-1 -: rntt_pkg::DivSteps];
    r     = rem_q;
    qbits = '0;
    for (int i = rntt_pkg::DivSteps - 1; i >= 0; i--) begin
      t = {r, chunk[i]};
      if (t >= radix_q) begin
        qbits[i] = 1'b1;
        r        = rntt_pkg::DigitW'(t - radix_q);
      end else begin
        r = t[rntt_pkg::DigitW-1:0];
      end
    end
    rem_d = r;
    div_d = (div_q << rntt_pkg::DivSteps) | rntt_pkg::DivW'(qbits);
  end

  assign step_last = (step_q == rntt_pkg::StepCntW'(rntt_pkg::StepsPerDigit - 1));
  assign cnt_dec   = cnt_q - 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      div_q <= rntt_pkg::DivW'(mag);
      rem_q <= '0;
    end else if (cmd_i.step) begin
      div_q <= div_d;
      rem_q <= step_last ? '0 : rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      cnt_q   <= '0;
      minus_q <= 1'b0;
    end else if (cmd_i.load) begin
      step_q  <= '0;
      cnt_q   <= '0;
      minus_q <= neg;
    end else if (cmd_i.step) begin
      if (step_last) begin
        step_q <= '0;
        cnt_q  <= cnt_q + 1'b1;
      end else begin
        step_q <= step_q + 1'b1;
      end
    end else if (cmd_i.fetch) begin
      cnt_q <= cnt_dec;
    end
  end

  rntt_ram #(
    .Width(rntt_pkg::DigitW),
    .Depth(rntt_pkg::StoreDep)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.step && step_last),
    .waddr_i(cnt_q[rntt_pkg::AddrW-1:0]),
    .wdata_i(rem_d),
    .re_i   (cmd_i.fetch),
    .raddr_i(cnt_dec[rntt_pkg::AddrW-1:0]),
    .rdata_o(rd_digit)
  );

  assign status_o.step_last = step_last;
  assign status_o.quo_zero  = (div_d == '0);
  assign status_o.minus     = minus_q;
  assign status_o.cnt_zero  = (cnt_q == '0);

  assign char_code_o = cmd_i.emit_minus ? rntt_pkg::CharMinus
                     : rntt_pkg::digit_char(rd_digit, flags_q[rntt_pkg::FlagLower]);
  assign last_char_o = !cmd_i.emit_minus && (cnt_q == '0);

endmodule

// ----- design/rntt_ctrl.sv -----
// ----------------------------------------------------------------------------
// Radix number to text: controller
// Sequences load, digit extraction, sign and digit output.
// ----------------------------------------------------------------------------
module rntt_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  rntt_pkg::rntt_status_t status_i,
  output rntt_pkg::rntt_cmd_t    cmd_o
);

  rntt_pkg::rntt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rntt_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rntt_pkg::StIdle: begin
        if (in_valid_i) state_d = rntt_pkg::StDivide;
      end
      rntt_pkg::StDivide: begin
        if (status_i.step_last && status_i.quo_zero) begin
          state_d = status_i.minus ? rntt_pkg::StSign : rntt_pkg::StFetch;
        end
      end
      rntt_pkg::StSign: begin
        if (out_ready_i) state_d = rntt_pkg::StFetch;
      end
      rntt_pkg::StFetch: state_d = rntt_pkg::StSend;
      rntt_pkg::StSend: begin
        if (out_ready_i) begin
          state_d = status_i.cnt_zero ? rntt_pkg::StIdle : rntt_pkg::StFetch;
        end
      end
      default: state_d = rntt_pkg::StIdle;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      rntt_pkg::StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      rntt_pkg::StDivide: cmd_o.step = 1'b1;
      rntt_pkg::StSign: begin
        out_valid_o      = 1'b1;
        cmd_o.emit_minus = 1'b1;
      end
      rntt_pkg::StFetch: cmd_o.fetch = 1'b1;
      rntt_pkg::StSend:  out_valid_o = 1'b1;
      default: ;
    endcase
  end

endmodule

// ----- design/rntt_checker.sv -----
// ----------------------------------------------------------------------------
// Radix number to text: port checker
// Concurrent assertions on the top-level ports, bound to the core.
// ----------------------------------------------------------------------------
`include "radix_number_to_text_core_assert.svh"

module rntt_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [rntt_pkg::CharW-1:0]   char_code_o,
  input logic                         last_char_o
);

  // A stalled character holds its value.
  `RNTT_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                    out_valid_o && $stable(char_code_o) && $stable(last_char_o))

  // Only one word is in flight: no output while the input side is open.
  `RNTT_ASSERT_SAME(a_idle_quiet, in_ready_o, !out_valid_o)

  // An accepted word closes the input until its text is done.
  `RNTT_ASSERT_NEXT(a_busy_after_take, in_valid_i && in_ready_o, !in_ready_o)

  // The final character transfer returns the core to idle.
  `RNTT_ASSERT_NEXT(a_idle_after_last, out_valid_o && out_ready_i && last_char_o, in_ready_o)

endmodule

bind radix_number_to_text_core rntt_checker u_rntt_checker (.*);
